// File: design/dte_pkg.sv
// ----------------------------------------------------------------------------
// dte_pkg: shared types and constants for the date/time to epoch converter
// Request and response payloads, inter-stage bundles and calendar tables.
// ----------------------------------------------------------------------------
`default_nettype none

package dte_pkg;

   // Year widening and range limits
   localparam logic [11:0] YEAR_PIVOT   = 12'd70;
   localparam logic [11:0] YEAR_CENTURY = 12'd100;
   localparam logic [11:0] YEAR_BASE    = 12'd1900;
   localparam logic [11:0] YEAR_FIRST   = 12'd1970;
   localparam logic [11:0] YEAR_LIMIT   = 12'd2038;

   // Calendar limits
   localparam logic [3:0]  MONTH_FIRST  = 4'd1;
   localparam logic [3:0]  MONTH_LAST   = 4'd12;
   localparam logic [3:0]  MONTH_FEB    = 4'd2;
   localparam logic [4:0]  DAY_FIRST    = 5'd1;

   // Time-of-day limits and scale factors
   localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
   localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

   // Request payload
   typedef struct packed {
      logic [3:0]  month_in;
      logic [4:0]  day_in;
      logic [11:0] year_in;
      logic [4:0]  hour_in;
      logic [5:0]  minute_in;
      logic [5:0]  second_in;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [30:0] epoch_seconds;
      logic [14:0] day_count;
      logic        date_ok;
      logic        time_ok;
   } rsp_type;

   // Stage 1 -> stage 2: checked date, split into year offset and day of year
   typedef struct packed {
      logic        date_ok;
      logic        time_ok;
      logic [6:0]  year_ofs;
      logic [8:0]  month_days;
      logic [4:0]  day_ofs;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } s1_type;

   // Stage 2 -> stage 3: day count and minutes of the day
   typedef struct packed {
      logic        date_ok;
      logic        time_ok;
      logic [14:0] day_count;
      logic [10:0] hour_min;
      logic [5:0]  second;
   } s2_type;

   // Stage 3 -> stage 4: seconds of the whole days and of the time of day
   typedef struct packed {
      logic        date_ok;
      logic        time_ok;
      logic [14:0] day_count;
      logic [30:0] day_secs;
      logic [16:0] tod_secs;
   } s3_type;

   // Length of a month; zero for month codes that name no month
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the year before the first of a month
   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      unique case (month)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (month > MONTH_FEB)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

`default_nettype wire

// File: design/datetime_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// datetime_to_epoch_seconds: calendar date and time of day to Unix seconds
// Four-stage pipeline: check, day count, scale, sum.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge where start is high and busy is low;
// busy is high while reset is applied and in the cycle after it is released,
// so after that one request can enter every cycle. Each request gives exactly
// one response, shown on rsp_data with rsp_valid high for one cycle once it
// has passed the four register stages (date check, day sum, the 15x17 seconds
// multiply, final add), in request order. The receiver cannot hold responses
// off, so the response must be captured in the cycle rsp_valid is high.
`default_nettype none

module datetime_to_epoch_seconds
   import dte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic    busy_ff;
   logic    req_accept;
   logic    s1_valid_ff;
   s1_type  s1_data_ff;
   logic    s2_valid_ff;
   s2_type  s2_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Hold off requests while reset is applied and in the cycle after it is released
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy       = busy_ff || reset;
   assign req_accept = start && !busy;

   dte_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_accept),
      .req_data    (req_data),
      .s1_valid_ff (s1_valid_ff),
      .s1_data_ff  (s1_data_ff)
   );

   dte_days u_days (
      .clock       (clock),
      .reset       (reset),
      .s1_valid_ff (s1_valid_ff),
      .s1_data_ff  (s1_data_ff),
      .s2_valid_ff (s2_valid_ff),
      .s2_data_ff  (s2_data_ff)
   );

   dte_secs u_secs (
      .clock        (clock),
      .reset        (reset),
      .s2_valid_ff  (s2_valid_ff),
      .s2_data_ff   (s2_data_ff),
      .rsp_valid_ff (rsp_valid_ff),
      .rsp_data_ff  (rsp_data_ff)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: design/dte_check.sv
// ----------------------------------------------------------------------------
// dte_check: stage 1 of the converter
// Widens the year, validates date and time, and splits the date into a year
// offset from 1970 and a day offset within the year.
// ----------------------------------------------------------------------------
`default_nettype none

module dte_check
   import dte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_data,
   output logic         s1_valid_ff,
   output s1_type       s1_data_ff
);

   logic [11:0] year_pivot;
   logic [11:0] year_full;
   logic        year_ok;
   logic        leap;
   logic        month_ok;
   logic        day_ok;
   s1_type      s1_data_in;

   // Widen two-digit and short years
   always_comb begin
      year_pivot = (req_data.year_in < YEAR_PIVOT) ? (req_data.year_in + YEAR_CENTURY)
                                                   : req_data.year_in;
      year_full  = (year_pivot < YEAR_BASE) ? (year_pivot + YEAR_BASE) : year_pivot;
   end

   // Check the date; inside 1970..2037 every fourth year is a leap year
   always_comb begin
      year_ok  = (year_full >= YEAR_FIRST) && (year_full < YEAR_LIMIT);
      leap     = (year_full[1:0] == 2'd0);
      month_ok = (req_data.month_in >= MONTH_FIRST) && (req_data.month_in <= MONTH_LAST);
      day_ok   = (req_data.day_in >= DAY_FIRST) &&
                 (req_data.day_in <= month_len(req_data.month_in, leap));
   end

   // Build the stage 1 bundle
   always_comb begin
      s1_data_in.date_ok    = year_ok && month_ok && day_ok;
      s1_data_in.time_ok    = (req_data.hour_in < HOURS_PER_DAY) &&
                              (req_data.minute_in < MINS_PER_HOUR) &&
                              (req_data.second_in < SECS_PER_MIN);
      s1_data_in.year_ofs   = 7'(year_full - YEAR_FIRST);
      s1_data_in.month_days = month_start(req_data.month_in, leap);
      s1_data_in.day_ofs    = req_data.day_in - DAY_FIRST;
      s1_data_in.hour       = req_data.hour_in;
      s1_data_in.minute     = req_data.minute_in;
      s1_data_in.second     = req_data.second_in;
   end

   // Advance the valid bit; payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_valid;
      end
      s1_data_ff <= s1_data_in;
   end

endmodule

`default_nettype wire

// File: design/dte_days.sv
// ----------------------------------------------------------------------------
// dte_days: stage 2 of the converter
// Sums whole years, leap days and the day of year into the day count, and
// folds hours into minutes of the day.
// ----------------------------------------------------------------------------
`default_nettype none

module dte_days
   import dte_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   s1_valid_ff,
   input  wire s1_type s1_data_ff,
   output logic        s2_valid_ff,
   output s2_type      s2_data_ff
);

   logic [14:0] year_days;
   logic [4:0]  leap_days;
   logic [14:0] day_sum;
   s2_type      s2_data_in;

   // Leap years in 1970..year-1 number (year - 1969) / 4
   always_comb begin
      year_days = 15'(s1_data_ff.year_ofs) * 15'(DAYS_PER_YEAR);
      leap_days = 5'((8'(s1_data_ff.year_ofs) + 8'd1) >> 2);
      day_sum   = year_days + 15'(leap_days) + 15'(s1_data_ff.month_days) +
                  15'(s1_data_ff.day_ofs);
   end

   // Zero the day count for an invalid date
   always_comb begin
      s2_data_in.date_ok   = s1_data_ff.date_ok;
      s2_data_in.time_ok   = s1_data_ff.time_ok;
      s2_data_in.day_count = s1_data_ff.date_ok ? day_sum : 15'd0;
      s2_data_in.hour_min  = 11'(s1_data_ff.minute) +
                             11'(s1_data_ff.hour) * 11'(MINS_PER_HOUR);
      s2_data_in.second    = s1_data_ff.second;
   end

   // Advance the valid bit; payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_data_ff <= s2_data_in;
   end

endmodule

`default_nettype wire

// File: design/dte_secs.sv
// ----------------------------------------------------------------------------
// dte_secs: stages 3 and 4 of the converter
// Scales days and minutes to seconds, then adds them and applies the
// time-valid flag to form the response.
// ----------------------------------------------------------------------------
`default_nettype none

module dte_secs
   import dte_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   s2_valid_ff,
   input  wire s2_type s2_data_ff,
   output logic        rsp_valid_ff,
   output rsp_type     rsp_data_ff
);

   logic [31:0] day_prod;
   s3_type      s3_data_in;
   s3_type      s3_data_ff;
   logic        s3_valid_ff;
   rsp_type     rsp_data_in;

   // Stage 3: one 15x17 multiply for the whole days
   always_comb begin
      day_prod              = 32'(s2_data_ff.day_count) * 32'(SECS_PER_DAY);
      s3_data_in.date_ok    = s2_data_ff.date_ok;
      s3_data_in.time_ok    = s2_data_ff.time_ok;
      s3_data_in.day_count  = s2_data_ff.day_count;
      s3_data_in.day_secs   = day_prod[30:0];
      s3_data_in.tod_secs   = 17'(s2_data_ff.second) +
                              17'(s2_data_ff.hour_min) * 17'(SECS_PER_MIN);
   end

   // Stage 4: add, then zero both counts for a bad time, keeping both flags
   always_comb begin
      rsp_data_in.date_ok = s3_data_ff.date_ok;
      rsp_data_in.time_ok = s3_data_ff.time_ok;
      if (s3_data_ff.time_ok) begin
         rsp_data_in.epoch_seconds = s3_data_ff.day_secs + 31'(s3_data_ff.tod_secs);
         rsp_data_in.day_count     = s3_data_ff.day_count;
      end else begin
         rsp_data_in.epoch_seconds = 31'd0;
         rsp_data_in.day_count     = 15'd0;
      end
   end

   // Advance valid bits; payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
      s3_data_ff  <= s3_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: design/dte_checker.sv
// ----------------------------------------------------------------------------
// dte_checker: port-level checks for the date/time converter
// Latency, response count and consistency of the response fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dte_checker
   import dte_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // Every response comes from a request taken earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("response without a matching request");

   // Every request taken with reset staying low after it gives a response
   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy, 4) && !$past(reset, 4) && !$past(reset, 3) &&
       !$past(reset, 2) && !$past(reset, 1)) |-> rsp_valid)
      else $error("request lost");

   // A bad time zeroes both counts; a bad date zeroes the day count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.time_ok || (rsp_data.epoch_seconds == 31'd0 &&
                      rsp_data.day_count == 15'd0)) &&
                     (rsp_data.date_ok || rsp_data.day_count == 15'd0)))
      else $error("invalid input gave nonzero count");

   // Seconds fall inside the day named by the day count
   a_secs_in_day: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.time_ok) |->
         ((32'(rsp_data.epoch_seconds) >= 32'(rsp_data.day_count) * 32'(SECS_PER_DAY)) &&
          (32'(rsp_data.epoch_seconds) - 32'(rsp_data.day_count) * 32'(SECS_PER_DAY)
           < 32'(SECS_PER_DAY))))
      else $error("seconds disagree with day count");

endmodule

bind datetime_to_epoch_seconds dte_checker u_dte_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
